// ----- hw/rtl/tgr_pkg.sv -----
package tgr_pkg;

   // Field widths
   localparam int PAD_W   = 3;
   localparam int CODE_W  = 3;
   localparam int COUNT_W = 8;
   localparam int TICK_W  = 16;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_SHORT_MIN   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_LONG_A      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LONG_B      = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_MAX_TICKS   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_REPEAT_WIN  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_COMBO_WIN   = 3'd5;

   // Register reset values
   localparam logic [TICK_W-1:0] RST_SHORT_MIN  = 16'd10;
   localparam logic [TICK_W-1:0] RST_LONG_A     = 16'd3000;
   localparam logic [TICK_W-1:0] RST_LONG_B     = 16'd12000;
   localparam logic [TICK_W-1:0] RST_MAX_TICKS  = 16'd60000;
   localparam logic [TICK_W-1:0] RST_REPEAT_WIN = 16'd500;
   localparam logic [TICK_W-1:0] RST_COMBO_WIN  = 16'd3000;

   // Event codes
   localparam logic [CODE_W-1:0] EV_SHORT        = 3'd0;
   localparam logic [CODE_W-1:0] EV_REPEAT_SHORT = 3'd1;
   localparam logic [CODE_W-1:0] EV_LONG_A       = 3'd2;
   localparam logic [CODE_W-1:0] EV_LONG_B       = 3'd3;
   localparam logic [CODE_W-1:0] EV_REJOIN       = 3'd4;
   localparam logic [CODE_W-1:0] EV_MULTI        = 3'd5;
   localparam logic [CODE_W-1:0] EV_NET_OPEN     = 3'd6;
   localparam logic [CODE_W-1:0] EV_HOLD_STOP    = 3'd7;

   // Run counts that select combination events
   localparam logic [COUNT_W-1:0] CNT_MAX       = 8'd255;
   localparam logic [COUNT_W-1:0] CNT_TRIPLE    = 8'd3;
   localparam logic [COUNT_W-1:0] CNT_FIVE      = 8'd5;
   localparam logic [COUNT_W-1:0] CNT_TEN       = 8'd10;

   typedef struct packed {
      logic [TICK_W-1:0] short_min;
      logic [TICK_W-1:0] long_a;
      logic [TICK_W-1:0] long_b;
      logic [TICK_W-1:0] max_ticks;
      logic [TICK_W-1:0] repeat_win;
      logic [TICK_W-1:0] combo_win;
   } tgr_cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0]  event_code;
      logic [PAD_W-1:0]   pad_pattern;
      logic [COUNT_W-1:0] press_count;
      logic               last_event;
   } tgr_result_type;

   typedef struct packed {
      logic       pop;
      logic [1:0] push_n;
   } tgr_queue_ctl_type;

endpackage

// ----- hw/rtl/tgr_if.sv -----
interface tgr_req_if import tgr_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PAD_W-1:0] pad_bits;

   modport source (output valid, output pad_bits, input ready);
   modport sink   (input valid, input pad_bits, output ready);
endinterface

interface tgr_rsp_if import tgr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CODE_W-1:0]  event_code;
   logic [PAD_W-1:0]   pad_pattern;
   logic [COUNT_W-1:0] press_count;
   logic               last_event;

   modport source (output valid, output event_code, output pad_pattern,
                   output press_count, output last_event, input ready);
   modport sink   (input valid, input event_code, input pad_pattern,
                   input press_count, input last_event, output ready);
endinterface

// ----- hw/rtl/touch_gesture_recognizer.sv -----
// Touch gesture recognizer for three pads. Each accepted req item is one pad
// sample (one timer tick); the block times each press and emits zero, one or
// two rsp items per tick: short / repeat short on release, one-shot long A
// (or rejoin after three shorts) and long B while held, and a multi-press
// count once the repeat window runs out (network open for a five-run inside
// the combo window after a triple run, hold stop for a ten-run). last_event
// marks the final rsp item of a tick. Throughput is one tick per clock: the
// whole tick update is one pass of compare/increment logic off the state
// registers, and results land in a QUEUE_DEPTH-entry queue that drains at one
// item per clock. req.ready is high while the queue has two free slots, so
// sustained rate drops only when ticks produce two events faster than rsp
// drains them, or when rsp stalls. Config registers (16 bit, byte address
// 4*index): short_min, long_a, long_b, max_ticks, repeat_window,
// combo_window; write them only while the block is idle.
module touch_gesture_recognizer import tgr_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   tgr_req_if.sink               req,
   tgr_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   tgr_cfg_type cfg;

   tgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Gesture state
   logic               pressed_ff,  pressed_in;
   logic [PAD_W-1:0]   pattern_ff,  pattern_in;
   logic [TICK_W-1:0]  held_ff,     held_in;
   logic [TICK_W-1:0]  rep_win_ff,  rep_win_in;
   logic [COUNT_W-1:0] rep_cnt_ff,  rep_cnt_in;
   logic               long_a_ff,   long_a_in;
   logic               long_b_ff,   long_b_in;
   logic [COUNT_W-1:0] short_run_ff, short_run_in;
   logic               rejoin_ff,   rejoin_in;
   logic               open_ff,     open_in;
   logic [TICK_W-1:0]  combo_win_ff, combo_win_in;

   logic [COUNT_W-1:0] run_cnt;
   logic [1:0]         n_emit;
   tgr_result_type     res0, res1;
   tgr_result_type     multi_res;
   logic               accept;

   tgr_queue_ctl_type  q_ctl;
   tgr_result_type     q_head;
   logic               q_not_empty;
   logic               q_room;

   assign req.ready = q_room;
   assign accept    = req.valid & req.ready;

   // One tick: age the counters first, then evaluate the sample.
   always_comb begin
      pressed_in   = pressed_ff;
      pattern_in   = pattern_ff;
      rep_cnt_in   = rep_cnt_ff;
      long_a_in    = long_a_ff;
      long_b_in    = long_b_ff;
      short_run_in = short_run_ff;
      rejoin_in    = rejoin_ff;
      run_cnt      = '0;
      n_emit       = 2'd0;
      res0         = '0;
      res1         = '0;
      multi_res    = '0;

      // held time saturates at max_ticks (clamped down if it lies above)
      if (pressed_ff) begin
         held_in = (held_ff >= cfg.max_ticks) ? cfg.max_ticks : held_ff + 16'd1;
      end else begin
         held_in = held_ff;
      end
      rep_win_in   = (rep_win_ff != '0) ? rep_win_ff - 16'd1 : rep_win_ff;
      combo_win_in = (combo_win_ff != '0) ? combo_win_ff - 16'd1 : combo_win_ff;
      open_in      = (combo_win_in == '0) ? 1'b0 : open_ff;

      if (req.pad_bits != '0) begin
         if (!pressed_ff) begin
            // press start
            pressed_in = 1'b1;
            held_in    = '0;
            rep_win_in = cfg.repeat_win;
            pattern_in = req.pad_bits;
         end else if (req.pad_bits == pattern_ff) begin
            // long A and long B bands are disjoint: at most one fires
            if (held_in > cfg.long_a && held_in <= cfg.long_b && !long_a_ff) begin
               long_a_in        = 1'b1;
               res0.event_code  = rejoin_ff ? EV_REJOIN : EV_LONG_A;
               res0.pad_pattern = pattern_ff;
               n_emit           = 2'd1;
               short_run_in     = 8'd1;
               rejoin_in        = 1'b0;
               open_in          = 1'b0;
            end
            if (held_in > cfg.long_b && held_in <= cfg.max_ticks && !long_b_ff) begin
               long_b_in        = 1'b1;
               res0.event_code  = EV_LONG_B;
               res0.pad_pattern = pattern_ff;
               n_emit           = 2'd1;
               short_run_in     = 8'd1;
               rejoin_in        = 1'b0;
               open_in          = 1'b0;
            end
         end
      end else begin
         // release (or idle sample)
         if (pressed_ff && held_in > cfg.short_min && held_in <= cfg.long_a) begin
            if (rep_win_in != '0 && rep_cnt_in != CNT_MAX) begin
               rep_cnt_in = rep_cnt_in + 8'd1;
            end
            res0.pad_pattern = pattern_ff;
            n_emit           = 2'd1;
            if (rep_cnt_in <= 8'd1) begin
               res0.event_code = EV_SHORT;
               short_run_in    = 8'd1;
               rejoin_in       = 1'b0;
            end else begin
               if (short_run_in != CNT_MAX) begin
                  short_run_in = short_run_in + 8'd1;
               end
               rejoin_in       = (short_run_in == CNT_TRIPLE);
               res0.event_code = EV_REPEAT_SHORT;
            end
         end

         // repeat window over: report the run
         if (rep_win_in == '0 && rep_cnt_in != '0) begin
            run_cnt    = rep_cnt_in;
            rep_cnt_in = '0;
            if (run_cnt >= 8'd2) begin
               if (run_cnt == CNT_FIVE && open_in) begin
                  multi_res.event_code = EV_NET_OPEN;
               end else if (run_cnt == CNT_TEN) begin
                  multi_res.event_code = EV_HOLD_STOP;
               end else begin
                  multi_res.event_code = EV_MULTI;
               end
               multi_res.pad_pattern = pattern_ff;
               multi_res.press_count = run_cnt;
               if (n_emit == 2'd0) begin
                  res0 = multi_res;
               end else begin
                  res1 = multi_res;
               end
               n_emit = n_emit + 2'd1;
               if (run_cnt == CNT_TRIPLE) begin
                  open_in      = 1'b1;
                  combo_win_in = cfg.combo_win;
               end else begin
                  open_in = 1'b0;
               end
               short_run_in = 8'd1;
               rejoin_in    = 1'b0;
            end
            pattern_in = '0;
         end

         long_a_in  = 1'b0;
         long_b_in  = 1'b0;
         held_in    = '0;
         pressed_in = 1'b0;
      end

      // tag the last item of the tick
      if (n_emit == 2'd1) begin
         res0.last_event = 1'b1;
      end else if (n_emit == 2'd2) begin
         res1.last_event = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff   <= 1'b0;
         pattern_ff   <= '0;
         held_ff      <= '0;
         rep_win_ff   <= '0;
         rep_cnt_ff   <= '0;
         long_a_ff    <= 1'b0;
         long_b_ff    <= 1'b0;
         short_run_ff <= 8'd1;
         rejoin_ff    <= 1'b0;
         open_ff      <= 1'b0;
         combo_win_ff <= '0;
      end else if (accept) begin
         pressed_ff   <= pressed_in;
         pattern_ff   <= pattern_in;
         held_ff      <= held_in;
         rep_win_ff   <= rep_win_in;
         rep_cnt_ff   <= rep_cnt_in;
         long_a_ff    <= long_a_in;
         long_b_ff    <= long_b_in;
         short_run_ff <= short_run_in;
         rejoin_ff    <= rejoin_in;
         open_ff      <= open_in;
         combo_win_ff <= combo_win_in;
      end
   end

   // Result queue
   assign q_ctl.push_n = accept ? n_emit : 2'd0;
   assign q_ctl.pop    = rsp.valid & rsp.ready;

   tgr_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .ctl          (q_ctl),
      .push0        (res0),
      .push1        (res1),
      .not_empty    (q_not_empty),
      .room_for_two (q_room),
      .head         (q_head)
   );

   assign rsp.valid       = q_not_empty;
   assign rsp.event_code  = q_head.event_code;
   assign rsp.pad_pattern = q_head.pad_pattern;
   assign rsp.press_count = q_head.press_count;
   assign rsp.last_event  = q_head.last_event;

endmodule

// ----- hw/rtl/tgr_csr.sv -----
module tgr_csr import tgr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output tgr_cfg_type           cfg
);

   tgr_cfg_type          cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr_en;
   logic [TICK_W-1:0]    wval;
   logic [TICK_W-1:0]    rval;

   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wval       = csr_pwdata[TICK_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_SHORT_MIN:  cfg_in.short_min  = wval;
            REG_LONG_A:     cfg_in.long_a     = wval;
            REG_LONG_B:     cfg_in.long_b     = wval;
            REG_MAX_TICKS:  cfg_in.max_ticks  = wval;
            REG_REPEAT_WIN: cfg_in.repeat_win = wval;
            REG_COMBO_WIN:  cfg_in.combo_win  = wval;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SHORT_MIN:  rval = cfg_ff.short_min;
         REG_LONG_A:     rval = cfg_ff.long_a;
         REG_LONG_B:     rval = cfg_ff.long_b;
         REG_MAX_TICKS:  rval = cfg_ff.max_ticks;
         REG_REPEAT_WIN: rval = cfg_ff.repeat_win;
         REG_COMBO_WIN:  rval = cfg_ff.combo_win;
         default:        rval = '0;
      endcase
   end

   assign csr_prdata = {{(CSR_DATA_W-TICK_W){1'b0}}, rval};
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_min  <= RST_SHORT_MIN;
         cfg_ff.long_a     <= RST_LONG_A;
         cfg_ff.long_b     <= RST_LONG_B;
         cfg_ff.max_ticks  <= RST_MAX_TICKS;
         cfg_ff.repeat_win <= RST_REPEAT_WIN;
         cfg_ff.combo_win  <= RST_COMBO_WIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/tgr_out_queue.sv -----
module tgr_out_queue import tgr_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  tgr_queue_ctl_type ctl,
   input  tgr_result_type    push0,
   input  tgr_result_type    push1,
   output logic              not_empty,
   output logic              room_for_two,
   output tgr_result_type    head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tgr_result_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic [PTR_W-1:0]   wr_ptr_nx;

   assign wr_ptr_nx    = wr_ptr_ff + PTR_W'(1);
   assign not_empty    = (count_ff != '0);
   assign room_for_two = (count_ff <= CNT_W'(DEPTH - 2));
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff + PTR_W'(ctl.pop);
      wr_ptr_in = wr_ptr_ff + PTR_W'(ctl.push_n);
      count_in  = count_ff + CNT_W'(ctl.push_n) - CNT_W'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (ctl.push_n == 2'd2) begin
         entry_ff[wr_ptr_nx] <= push1;
      end
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top import tgr_pkg::*; ();

   // Quiet cycles (no item moving on either channel) before the run is declared hung.
   // The longest legal quiet stretch is the forced rsp hold-off plus a few
   // idle bursts.
   localparam int QUIET_LIMIT  = 4000;
   localparam int HOLD_OFF_LEN = 300;
   localparam int DRAIN_CYCLES = 16;

   // ---------------------------------------------------------------------
   // Gesture predictor and event checker
   // ---------------------------------------------------------------------
   class gesture_scoreboard;
      tgr_cfg_type          cfg;
      logic                 pressed;
      logic                 fired_a;
      logic                 fired_b;
      logic                 rejoin_armed;
      logic                 open_armed;
      logic [PAD_W-1:0]     held_pattern;
      logic [TICK_W-1:0]    held_ticks;
      logic [TICK_W-1:0]    repeat_left;
      logic [TICK_W-1:0]    combo_left;
      logic [COUNT_W-1:0]   repeat_count;
      logic [COUNT_W-1:0]   short_runs;
      tgr_result_type       pending_events[$];
      tgr_result_type       tick_events[$];
      int                   errors;

      function new();
         cfg = {RST_SHORT_MIN, RST_LONG_A, RST_LONG_B, RST_MAX_TICKS,
                RST_REPEAT_WIN, RST_COMBO_WIN};
         pressed      = 1'b0;
         fired_a      = 1'b0;
         fired_b      = 1'b0;
         rejoin_armed = 1'b0;
         open_armed   = 1'b0;
         held_pattern = '0;
         held_ticks   = '0;
         repeat_left  = '0;
         combo_left   = '0;
         repeat_count = '0;
         short_runs   = 8'd1;
         errors       = 0;
      endfunction

      function void write_reg(input logic [REG_IDX_W-1:0] idx,
                              input logic [TICK_W-1:0] value);
         case (idx)
            REG_SHORT_MIN:  cfg.short_min  = value;
            REG_LONG_A:     cfg.long_a     = value;
            REG_LONG_B:     cfg.long_b     = value;
            REG_MAX_TICKS:  cfg.max_ticks  = value;
            REG_REPEAT_WIN: cfg.repeat_win = value;
            REG_COMBO_WIN:  cfg.combo_win  = value;
            default: ;
         endcase
      endfunction

      function void post_event(input logic [CODE_W-1:0] code,
                               input logic [COUNT_W-1:0] count);
         tgr_result_type ev;
         if (tick_events.size() >= 2) return;
         ev.event_code  = code;
         ev.pad_pattern = held_pattern;
         ev.press_count = count;
         ev.last_event  = 1'b0;
         tick_events.push_back(ev);
      endfunction

      function void restart_runs(input bit keep_open);
         short_runs   = 8'd1;
         rejoin_armed = 1'b0;
         if (!keep_open) open_armed = 1'b0;
      endfunction

      // One accepted pad sample = one tick.
      function void predict_tick(input logic [PAD_W-1:0] pads);
         logic [COUNT_W-1:0] run_len;
         logic [CODE_W-1:0]  code;
         tgr_result_type     ev;
         tick_events.delete();

         if (pressed)
            held_ticks = (held_ticks >= cfg.max_ticks) ? cfg.max_ticks
                                                       : held_ticks + 16'd1;
         if (repeat_left != 0) repeat_left = repeat_left - 16'd1;
         if (combo_left != 0) combo_left = combo_left - 16'd1;
         if (combo_left == 0) open_armed = 1'b0;

         if (pads != 0) begin
            if (!pressed) begin
               pressed      = 1'b1;
               held_ticks   = '0;
               repeat_left  = cfg.repeat_win;
               held_pattern = pads;
            end else if (pads == held_pattern) begin
               if (held_ticks > cfg.long_a && held_ticks <= cfg.long_b && !fired_a) begin
                  fired_a = 1'b1;
                  post_event(rejoin_armed ? EV_REJOIN : EV_LONG_A, '0);
                  restart_runs(1'b0);
               end
               if (held_ticks > cfg.long_b && held_ticks <= cfg.max_ticks && !fired_b) begin
                  fired_b = 1'b1;
                  post_event(EV_LONG_B, '0);
                  restart_runs(1'b0);
               end
            end
         end else begin
            if (pressed && held_ticks > cfg.short_min && held_ticks <= cfg.long_a) begin
               if (repeat_left != 0 && repeat_count < CNT_MAX)
                  repeat_count = repeat_count + 8'd1;
               if (repeat_count <= 8'd1) begin
                  post_event(EV_SHORT, '0);
                  restart_runs(1'b1);
               end else begin
                  if (short_runs < CNT_MAX) short_runs = short_runs + 8'd1;
                  rejoin_armed = (short_runs == CNT_TRIPLE);
                  post_event(EV_REPEAT_SHORT, '0);
               end
            end
            if (repeat_left == 0 && repeat_count != 0) begin
               run_len      = repeat_count;
               repeat_count = '0;
               if (run_len >= 8'd2) begin
                  code = EV_MULTI;
                  if (run_len == CNT_FIVE && open_armed) code = EV_NET_OPEN;
                  else if (run_len == CNT_TEN) code = EV_HOLD_STOP;
                  post_event(code, run_len);
                  if (run_len == CNT_TRIPLE) begin
                     open_armed = 1'b1;
                     combo_left = cfg.combo_win;
                  end
                  restart_runs(run_len == CNT_TRIPLE);
               end
               held_pattern = '0;
            end
            fired_a    = 1'b0;
            fired_b    = 1'b0;
            held_ticks = '0;
            pressed    = 1'b0;
         end

         foreach (tick_events[i]) begin
            ev = tick_events[i];
            ev.last_event = (i == tick_events.size() - 1);
            pending_events.push_back(ev);
         end
      endfunction

      task flag_mismatch(input string what);
         errors++;
         $display("%0t ns: %s", $time, what);
      endtask

      task check_event(input tgr_result_type got);
         tgr_result_type want;
         if (pending_events.size() == 0) begin
            flag_mismatch($sformatf("unexpected event, code %0d pattern %0d count %0d",
                                    got.event_code, got.pad_pattern, got.press_count));
            return;
         end
         want = pending_events.pop_front();
         if (got.event_code !== want.event_code)
            flag_mismatch($sformatf("event_code %0d, want %0d",
                                    got.event_code, want.event_code));
         if (got.pad_pattern !== want.pad_pattern)
            flag_mismatch($sformatf("pad_pattern %0d, want %0d (code %0d)",
                                    got.pad_pattern, want.pad_pattern, want.event_code));
         if (got.press_count !== want.press_count)
            flag_mismatch($sformatf("press_count %0d, want %0d (code %0d)",
                                    got.press_count, want.press_count, want.event_code));
         if (got.last_event !== want.last_event)
            flag_mismatch($sformatf("last_event %0b, want %0b (code %0d)",
                                    got.last_event, want.last_event, want.event_code));
      endtask
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   tgr_req_if req_if ();
   tgr_rsp_if rsp_if ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   touch_gesture_recognizer DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gesture_scoreboard sb;
   tgr_result_type    rsp_seen;
   int                samples_sent = 0;
   int                quiet_cycles = 0;
   bit                idle_on = 1'b1;     // random gaps / stalls enabled
   bit                hold_off_req = 1'b0; // ask the rsp side for one long stall

   // ---------------------------------------------------------------------
   // Monitors: sample handshakes at the edge, before any NBA lands
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) sb.predict_tick(req_if.pad_bits);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_seen = {rsp_if.event_code, rsp_if.pad_pattern, rsp_if.press_count,
                     rsp_if.last_event};
         sb.check_event(rsp_seen);
      end
   end

   // Watchdog: counts cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // rsp side: random stall bursts, plus one long hold-off on request so
   // the result queue fills and req.ready has to drop
   // ---------------------------------------------------------------------
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // req side drivers
   // ---------------------------------------------------------------------

   // Offer one pad sample and return at the edge that accepts it. valid is
   // left high so back-to-back samples need no extra NBA in the same step.
   task send_sample(input logic [PAD_W-1:0] pads);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.pad_bits <= pads;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      samples_sent++;
   endtask

   task hold_pads(input logic [PAD_W-1:0] pads, input int ticks);
      repeat (ticks) send_sample(pads);
   endtask

   // Held time that lands in the short band, if the band is reachable.
   // Holding pads for n samples gives held_ticks == n at the release.
   function automatic int short_hold();
      int lo;
      int hi;
      lo = int'(sb.cfg.short_min) + 1;
      hi = int'(sb.cfg.long_a);
      if (lo > 40) return $urandom_range(1, 40);
      if (hi < lo) return lo;
      return lo + $urandom_range(0, (hi - lo > 2) ? 2 : hi - lo);
   endfunction

   function automatic int long_hold();
      int t;
      t = ($urandom_range(0, 1) ? int'(sb.cfg.long_a) : int'(sb.cfg.long_b))
          + 1 + $urandom_range(0, 3);
      if (t > 60) t = $urandom_range(20, 60);
      return t;
   endfunction

   // Released stretch long enough for the repeat window to run out, when repeat_win + 2 is at most 40
   function automatic int expire_gap();
      int g;
      g = int'(sb.cfg.repeat_win) + 2;
      return (g > 40) ? $urandom_range(1, 40) : g;
   endfunction

   // A run of short presses, each started inside the previous repeat window
   task press_run(input int presses);
      int gap_ticks;
      repeat (presses) begin
         gap_ticks = (sb.cfg.repeat_win < 8) ? 1 : $urandom_range(1, 2);
         hold_pads(PAD_W'($urandom_range(1, 7)), short_hold());
         hold_pads('0, gap_ticks);
      end
   endtask

   // Mostly well-formed gestures with random content, the rest noise
   task random_gestures(input int budget);
      int stop_at;
      int kind;
      stop_at = samples_sent + budget;
      while (samples_sent < stop_at) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            // multi press, sometimes the ten-press hold stop
            press_run(($urandom_range(0, 3) == 0) ? 10 : $urandom_range(1, 6));
            hold_pads('0, expire_gap());
         end else if (kind < 50) begin
            // triple then five: network open while the combo window lasts
            press_run(3);
            hold_pads('0, expire_gap());
            press_run(5);
            hold_pads('0, expire_gap());
         end else if (kind < 60) begin
            // three shorts then a long press: rejoin instead of long A
            press_run(3);
            hold_pads(PAD_W'($urandom_range(1, 7)), long_hold());
            hold_pads('0, expire_gap());
         end else if (kind < 75) begin
            hold_pads(PAD_W'($urandom_range(1, 7)), long_hold());
            hold_pads('0, $urandom_range(1, 3));
         end else begin
            // raw noise: pattern changes while held, stray releases
            repeat ($urandom_range(1, 8)) send_sample(PAD_W'($urandom_range(0, 7)));
         end
      end
   endtask

   // Wait for every expected event, then a few cycles for ticks that
   // produce none, so the block is idle before a register write. The first
   // edge lets the monitor log the last accepted sample.
   task settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup, access, register updates at the access edge
   task csr_write(input logic [REG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task set_timing(input logic [TICK_W-1:0] short_min, input logic [TICK_W-1:0] long_a,
                   input logic [TICK_W-1:0] long_b, input logic [TICK_W-1:0] max_ticks,
                   input logic [TICK_W-1:0] repeat_win, input logic [TICK_W-1:0] combo_win);
      settle();
      csr_write(REG_SHORT_MIN, short_min);
      csr_write(REG_LONG_A, long_a);
      csr_write(REG_LONG_B, long_b);
      csr_write(REG_MAX_TICKS, max_ticks);
      csr_write(REG_REPEAT_WIN, repeat_win);
      csr_write(REG_COMBO_WIN, combo_win);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      sb = new();
      req_if.valid    <= 1'b0;
      req_if.pad_bits <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // Directed, reset timing: every pad value, a pattern change while held
      // (no long events), a release below the short band, then a clean short.
      send_sample(3'd1);
      send_sample(3'd1);
      send_sample(3'd2);
      send_sample(3'd4);
      send_sample(3'd3);
      send_sample(3'd5);
      send_sample(3'd6);
      send_sample(3'd7);
      send_sample(3'd0);
      hold_pads(3'd7, 13);
      send_sample(3'd0);

      // Compact timing so every event fits in a few dozen ticks. The rsp
      // side is held off once here while req keeps offering.
      set_timing(16'd2, 16'd8, 16'd20, 16'd30, 16'd12, 16'd80);
      hold_off_req = 1'b1;
      random_gestures(400);

      // All registers at zero: empty bands, held time pinned at zero
      set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      random_gestures(80);

      // All registers at full scale: nothing can reach any band
      set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_gestures(80);

      // One very long run drives repeat_count and short_runs into saturation
      set_timing(16'd0, 16'd1, 16'd3, 16'd5, 16'd8, 16'hFFFF);
      press_run(262);
      hold_pads('0, expire_gap());
      random_gestures(60);

      // Inconsistent registers: long B below long A, ceiling in between
      set_timing(16'd5, 16'd20, 16'd10, 16'd15, 16'd10, 16'd40);
      random_gestures(200);

      // Final stretch at full rate on both sides
      set_timing(16'd1, 16'd6, 16'd12, 16'd16, 16'd8, 16'd100);
      idle_on = 1'b0;
      random_gestures(340);

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.errors == 0 && sb.pending_events.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/tgr_pkg.sv
hw/rtl/tgr_if.sv
hw/rtl/tgr_csr.sv
hw/rtl/tgr_out_queue.sv
hw/rtl/touch_gesture_recognizer.sv
dv/tb_top.sv
